/* rtl/gsr_pkg.sv */
// Shared types and constants for the greedy shift-reduce parser.
// No dependencies.
package gsr_pkg;

    localparam int PROD_SLOTS = 7;
    localparam int PROD_WIDTH = 43;

    typedef logic [PROD_WIDTH-1:0] prod_t;

    typedef struct packed {
        prod_t [PROD_SLOTS-1:0] prod;
        logic [2:0]             count;
    } gsr_cfg_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT   = 2'd0,
        VERDICT_NOACTION = 2'd1,
        VERDICT_LIMIT    = 2'd2,
        VERDICT_OVERFLOW = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        REG_PROD_0 = 3'd0,
        REG_PROD_1 = 3'd1,
        REG_PROD_2 = 3'd2,
        REG_PROD_3 = 3'd3,
        REG_PROD_4 = 3'd4,
        REG_PROD_5 = 3'd5,
        REG_PROD_6 = 3'd6,
        REG_COUNT  = 3'd7
    } reg_idx_t;

endpackage

/* rtl/gsr_if.sv */
// Valid/ready channels for symbol items and verdict items.
// Depends on nothing.
interface gsr_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;

    modport source (output valid, symbol, last_symbol, input ready);
    modport sink (input valid, symbol, last_symbol, output ready);
endinterface

interface gsr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [5:0] action_total;
    logic [6:0] final_depth;

    modport source (output valid, verdict, action_total, final_depth, input ready);
    modport sink (input valid, verdict, action_total, final_depth, output ready);
endinterface

/* rtl/gsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/gsr_regs.sv */
// APB register file holding the grammar productions and production count.
// Depends on gsr_pkg.
module gsr_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [5:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output gsr_pkg::gsr_cfg_t cfg
);
    import gsr_pkg::*;

    gsr_cfg_t cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (idx == REG_COUNT)
            begin
                cfg_reg.count <= pwdata[2:0];
            end
            else
            begin
                cfg_reg.prod[paddr[5:3]] <= pwdata[PROD_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_COUNT: prdata = {61'b0, cfg_reg.count};
            REG_PROD_0, REG_PROD_1, REG_PROD_2, REG_PROD_3,
            REG_PROD_4, REG_PROD_5, REG_PROD_6:
                prdata = {{(64-PROD_WIDTH){1'b0}}, cfg_reg.prod[paddr[5:3]]};
            default:   prdata = '0;
        endcase
    end
endmodule

/* rtl/greedy_shift_reduce_parser.sv */
// Greedy shift-reduce parser: top level with sequencer and shared symbol comparator.
// Depends on gsr_pkg, gsr_if, gsr_ram, gsr_regs.
// Per item: accept in idle, run a reduction pass unless a verdict is held, then shift; a pass
// scans the productions, compares each right-side symbol and applies a reduction or ends the pass.
// A final item without a verdict runs one more pass; any final item then emits its result,
// waiting while results stalls. Ready only in idle. Reset clears control state, not the stack.
module greedy_shift_reduce_parser #(
    parameter int STACK_DEPTH     = 64,
    parameter int MAX_RHS_SYMBOLS = 4,
    parameter int ACTION_LIMIT    = 49
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    gsr_sym_if.sink     items,
    gsr_res_if.source   results
);
    import gsr_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(ACTION_LIMIT + 1);
    localparam logic [2:0] MAX_LEN = 3'(MAX_RHS_SYMBOLS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MATCH = 6'b000010,
        S_CMP   = 6'b000100,
        S_APPLY = 6'b001000,
        S_SHIFT = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    gsr_cfg_t cfg;

    state_t         state_reg, state_next;
    logic [2:0]     idx_reg, idx_next;
    logic [1:0]     k_reg, k_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           done_reg, done_next;
    verdict_t       verdict_reg, verdict_next;
    logic           consumed_reg, consumed_next;
    logic [7:0]     sym_reg, sym_next;
    logic           last_reg, last_next;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_verdict_reg, out_verdict_next;
    logic [5:0]     out_total_reg, out_total_next;
    logic [6:0]     out_depth_reg, out_depth_next;

    prod_t          cur_prod;
    logic [2:0]     cur_len;
    logic [7:0]     cur_left;
    logic [DW-1:0]  len_ext;
    logic           len_ok;
    logic [2:0]     rd_k;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     want;
    logic [7:0]     ram_rdata;
    logic           sym_eq;
    logic [CW-1:0]  count_inc;
    logic           limit_hit;
    logic           depth_full;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;

    gsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsr_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign items.ready          = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.verdict      = out_verdict_reg;
    assign results.action_total = out_total_reg;
    assign results.final_depth  = out_depth_reg;

    assign cur_prod   = cfg.prod[idx_reg];
    assign cur_len    = cur_prod[10:8];
    assign cur_left   = cur_prod[7:0];
    assign len_ext    = DW'(cur_len);
    assign len_ok     = (cur_len <= MAX_LEN) && (len_ext <= depth_reg);
    assign rd_k       = (state_reg == S_CMP) ? 3'(k_reg) + 3'd1 : 3'd0;
    assign rd_addr    = AW'(depth_reg - len_ext + DW'(rd_k));
    assign want       = cur_prod[11 + 8*k_reg +: 8];
    assign sym_eq     = (ram_rdata == want);
    assign count_inc  = count_reg + CW'(1);
    assign limit_hit  = (count_inc >= CW'(ACTION_LIMIT));
    assign depth_full = (depth_reg >= DW'(STACK_DEPTH));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        depth_next       = depth_reg;
        count_next       = count_reg;
        done_next        = done_reg;
        verdict_next     = verdict_reg;
        consumed_next    = consumed_reg;
        sym_next         = sym_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_verdict_next = out_verdict_reg;
        out_total_next   = out_total_reg;
        out_depth_next   = out_depth_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(depth_reg);
        ram_wdata        = sym_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    sym_next      = items.symbol;
                    last_next     = items.last_symbol;
                    consumed_next = 1'b0;
                    idx_next      = 3'd0;
                    state_next    = done_reg ? S_SHIFT : S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (idx_reg >= cfg.count)
                begin
                    state_next = consumed_reg ? S_EMIT : S_SHIFT;
                end
                else if (!len_ok)
                begin
                    idx_next = idx_reg + 3'd1;
                end
                else if (cur_len == 3'd0)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    k_next     = 2'd0;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!sym_eq)
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_MATCH;
                end
                else if (3'(k_reg) == cur_len - 3'd1)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_APPLY:
            begin
                if (cur_len == 3'd0 && depth_full)
                begin
                    done_next    = 1'b1;
                    verdict_next = VERDICT_OVERFLOW;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(depth_reg - len_ext);
                    ram_wdata  = cur_left;
                    depth_next = depth_reg - len_ext + DW'(1);
                    count_next = count_inc;
                    if (consumed_reg && depth_next == DW'(1) && cur_left == cfg.prod[0][7:0])
                    begin
                        done_next    = 1'b1;
                        verdict_next = VERDICT_ACCEPT;
                    end
                    else if (limit_hit)
                    begin
                        done_next    = 1'b1;
                        verdict_next = VERDICT_LIMIT;
                    end
                end
                if (done_next)
                begin
                    state_next = consumed_reg ? S_EMIT : S_SHIFT;
                end
                else
                begin
                    idx_next   = 3'd0;
                    state_next = S_MATCH;
                end
            end
            S_SHIFT:
            begin
                if (!done_reg)
                begin
                    if (depth_full)
                    begin
                        done_next    = 1'b1;
                        verdict_next = VERDICT_OVERFLOW;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        depth_next = depth_reg + DW'(1);
                        count_next = count_inc;
                        if (limit_hit)
                        begin
                            done_next    = 1'b1;
                            verdict_next = VERDICT_LIMIT;
                        end
                    end
                end
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (done_next)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    consumed_next = 1'b1;
                    idx_next      = 3'd0;
                    state_next    = S_MATCH;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = done_reg ? verdict_reg : VERDICT_NOACTION;
                    out_total_next   = 6'(count_reg);
                    out_depth_next   = 7'(depth_reg);
                    depth_next       = '0;
                    count_next       = '0;
                    done_next        = 1'b0;
                    verdict_next     = VERDICT_ACCEPT;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            k_reg         <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            verdict_reg   <= VERDICT_ACCEPT;
            consumed_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            verdict_reg   <= verdict_next;
            consumed_reg  <= consumed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        last_reg        <= last_next;
        out_verdict_reg <= out_verdict_next;
        out_total_reg   <= out_total_next;
        out_depth_reg   <= out_depth_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ACTION_LIMIT))
    else $error("action count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
    else $error("result raised outside emit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_valid_reg || results.ready)) |=>
            depth_reg == '0 && count_reg == '0 && !done_reg)
    else $error("string state not cleared after verdict");
endmodule

/* verif/testbench.sv */
// Self-checking bench for greedy_shift_reduce_parser: programs grammars over the APB port,
// sends symbol strings with random bursts and stalls, and checks every verdict item.
// Depends on gsr_pkg, gsr_if and the parser RTL.
module testbench;
    import gsr_pkg::*;

    typedef struct packed {
        verdict_t   verdict;
        logic [5:0] action_total;
        logic [6:0] final_depth;
    } verdict_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatches;
    int          verdicts_seen;
    int          verdict_hist [4];
    int          hold_cycles;
    logic [7:0]  alphabet [4];

    gsr_sym_if sym_ch ();
    gsr_res_if res_ch ();

    greedy_shift_reduce_parser i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .items   (sym_ch),
        .results (res_ch)
    );

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    class parse_scoreboard;
        prod_t         grammar [PROD_SLOTS];
        int unsigned   rule_count;
        logic [7:0]    stack [64];
        int unsigned   depth;
        int unsigned   actions;
        bit            finished;
        verdict_t      held_verdict;
        verdict_item_t awaited [$];

        function new();
            foreach (grammar[i]) grammar[i] = '0;
            rule_count   = 0;
            depth        = 0;
            actions      = 0;
            finished     = 0;
            held_verdict = VERDICT_ACCEPT;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] val);
            if (idx == REG_COUNT)
                rule_count = val[2:0];
            else
                grammar[idx] = val[PROD_WIDTH-1:0];
        endfunction

        function int first_rule();
            int unsigned len;
            bit          hit;
            for (int i = 0; i < rule_count; i++) begin
                len = grammar[i][10:8];
                if (len > 4 || depth < len)
                    continue;
                hit = 1;
                for (int k = 0; k < len; k++)
                    if (grammar[i][11+8*k +: 8] != stack[depth-len+k])
                        hit = 0;
                if (hit)
                    return i;
            end
            return -1;
        endfunction

        function void conclude(verdict_t v);
            finished     = 1;
            held_verdict = v;
        endfunction

        function void reduce_all(bit consumed);
            int          r;
            int unsigned len;
            while (!finished) begin
                r = first_rule();
                if (r < 0)
                    return;
                len = grammar[r][10:8];
                if (len == 0 && depth >= 64) begin
                    conclude(VERDICT_OVERFLOW);
                    return;
                end
                depth -= len;
                stack[depth] = grammar[r][7:0];
                depth++;
                actions++;
                if (consumed && depth == 1 && stack[0] == grammar[0][7:0]) begin
                    conclude(VERDICT_ACCEPT);
                    return;
                end
                if (actions >= 49) begin
                    conclude(VERDICT_LIMIT);
                    return;
                end
            end
        endfunction

        function void note_symbol(logic [7:0] sym, bit last);
            verdict_item_t expected_item;
            if (!finished)
                reduce_all(0);
            if (!finished) begin
                if (depth >= 64)
                    conclude(VERDICT_OVERFLOW);
                else begin
                    stack[depth] = sym;
                    depth++;
                    actions++;
                    if (actions >= 49)
                        conclude(VERDICT_LIMIT);
                end
            end
            if (!last)
                return;
            if (!finished)
                reduce_all(1);
            if (!finished)
                conclude(VERDICT_NOACTION);
            expected_item = '{held_verdict, actions[5:0], depth[6:0]};
            awaited = {awaited, expected_item};
            depth        = 0;
            actions      = 0;
            finished     = 0;
            held_verdict = VERDICT_ACCEPT;
        endfunction

        task check_verdict(verdict_t v, logic [5:0] acts, logic [6:0] dep);
            verdict_item_t want;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected verdict item", v, -1);
                return;
            end
            want = awaited.pop_front();
            if (v !== want.verdict)
                report_mismatch("verdict", v, want.verdict);
            if (acts !== want.action_total)
                report_mismatch("action_total", acts, want.action_total);
            if (dep !== want.final_depth)
                report_mismatch("final_depth", dep, want.final_depth);
        endtask
    endclass

    parse_scoreboard board;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #(12 * 4000000);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready) begin
            board.check_verdict(verdict_t'(res_ch.verdict), res_ch.action_total,
                                res_ch.final_depth);
            verdicts_seen++;
            verdict_hist[res_ch.verdict]++;
            if (verdicts_seen == 150)
                hold_cycles = 600;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            res_ch.ready <= 1'b0;
        end
        else if ((verdicts_seen / 40) % 3 == 0)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 2) != 0);
    end

    function automatic prod_t make_rule(logic [7:0] lhs, logic [2:0] len, logic [7:0] s0,
                                        logic [7:0] s1, logic [7:0] s2, logic [7:0] s3);
        return {s3, s2, s1, s0, len, lhs};
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.write_reg(idx, val);
    endtask

    task automatic drain();
        sym_ch.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    int burst_left;

    task automatic put_symbol(logic [7:0] sym, bit last);
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol      <= sym;
        sym_ch.last_symbol <= last;
        @(posedge clk);
        while (!sym_ch.ready)
            @(posedge clk);
        board.note_symbol(sym, last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                sym_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic send_strings(int item_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < item_budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
                put_symbol(($urandom_range(0, 6) == 0) ? 8'($urandom) :
                           alphabet[$urandom_range(0, 3)], k == len - 1);
            sent += len;
        end
    endtask

    task automatic load_random_grammar(int unsigned cnt);
        logic [2:0] len;
        for (int i = 0; i < PROD_SLOTS; i++) begin
            len = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) :
                  3'($urandom_range(1, 4));
            if ($urandom_range(0, 9) == 0)
                write_reg(reg_idx_t'(i), {$urandom, $urandom});
            else
                write_reg(reg_idx_t'(i), 64'(make_rule(alphabet[$urandom_range(0, 3)], len,
                          alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)],
                          alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)])));
        end
        write_reg(REG_COUNT, 64'(cnt));
    endtask

    initial
    begin
        board              = new();
        mismatches         = 0;
        verdicts_seen      = 0;
        hold_cycles        = 0;
        burst_left         = 0;
        foreach (verdict_hist[i]) verdict_hist[i] = 0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sym_ch.valid       = 1'b0;
        sym_ch.symbol      = '0;
        sym_ch.last_symbol = 1'b0;
        res_ch.ready       = 1'b0;
        alphabet           = '{8'h01, 8'h80, 8'h02, 8'hFF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_PROD_0, 64'(make_rule(8'hFF, 3'd3, 8'h01, 8'h80, 8'h02, 8'h00)));
        write_reg(REG_PROD_1, 64'(make_rule(8'h80, 3'd2, 8'h01, 8'h02, 8'h00, 8'h00)));
        write_reg(REG_PROD_2, 64'(make_rule(8'h80, 3'd4, 8'h80, 8'h80, 8'h80, 8'h80)));
        write_reg(REG_COUNT, 64'd3);
        put_symbol(8'hFF, 1'b1);
        put_symbol(8'h00, 1'b1);
        put_symbol(8'h01, 1'b0);
        put_symbol(8'h02, 1'b1);
        put_symbol(8'h01, 1'b0);
        put_symbol(8'h01, 1'b0);
        put_symbol(8'h02, 1'b0);
        put_symbol(8'h02, 1'b1);
        for (int k = 0; k < 12; k++)
            put_symbol(8'h80, k == 11);
        drain();

        write_reg(REG_PROD_6, 64'(make_rule(8'hFF, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF)));
        write_reg(REG_COUNT, 64'd0);
        send_strings(150);
        drain();

        write_reg(REG_PROD_3, 64'(make_rule(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00)));
        write_reg(REG_COUNT, 64'd4);
        send_strings(120);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            load_random_grammar(ph == 4 ? 7 : $urandom_range(1, 7));
            send_strings(270);
            drain();
        end

        drain();
        $display("Checked %0d verdicts: %0d accepted, %0d no action, %0d limit, %0d overflow",
                 verdicts_seen, verdict_hist[0], verdict_hist[1], verdict_hist[2],
                 verdict_hist[3]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
